@@ rtl/lhrb_pkg.sv @@
// ----------------------------------------------------------------------------
// lhrb_pkg
// Shared types and constants of the lattice Hamiltonian row builder.
// ----------------------------------------------------------------------------
package lhrb_pkg;

    localparam int PAT_W  = 32;
    localparam int SLOT_W = 12;
    localparam int VAL_W  = 48;
    localparam int COEF_W = 24;
    localparam int STAG_W = 7;
    localparam int SC_W   = 6;
    localparam int BC_W   = 13;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] CFG_SITE_COUNT    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_BASIS_COUNT   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_ONSITE_COEF   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_COUPLING_COEF = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_HOP_COEF      = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ROW  = 1'b1;

    typedef struct packed {
        logic                     done;
        logic signed [STAG_W-1:0] stag;
        logic signed [VAL_W-1:0]  value;
    } t_diag_res;

endpackage

@@ rtl/lhrb_req_if.sv @@
// ----------------------------------------------------------------------------
// lhrb_req_if
// Request channel: table loads and row builds.
// ----------------------------------------------------------------------------
interface lhrb_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] slot;
    logic [31:0] pattern;

    modport source (output valid, kind, slot, pattern, input ready);
    modport sink   (input valid, kind, slot, pattern, output ready);
endinterface

@@ rtl/lhrb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lhrb_rsp_if
// Result channel: one matrix entry per transfer.
// ----------------------------------------------------------------------------
interface lhrb_rsp_if;
    logic               valid;
    logic               ready;
    logic [11:0]        row;
    logic [11:0]        column;
    logic signed [47:0] matrix_value;
    logic               is_diagonal;
    logic signed [6:0]  stag_sum;
    logic               last;

    modport source (output valid, row, column, matrix_value, is_diagonal, stag_sum, last,
                     input ready);
    modport sink   (input valid, row, column, matrix_value, is_diagonal, stag_sum, last,
                     output ready);
endinterface

@@ rtl/lhrb_mem.sv @@
// ----------------------------------------------------------------------------
// lhrb_mem
// Basis table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lhrb_mem
    import lhrb_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PAT_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [PAT_W-1:0] o_rdata
);

    logic [PAT_W-1:0] mem [DEPTH];
    logic [PAT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lhrb_diag.sv @@
// ----------------------------------------------------------------------------
// lhrb_diag
// Diagonal energy: walks the sites one a cycle, then two multiplies and a sum.
// ----------------------------------------------------------------------------
module lhrb_diag
    import lhrb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [PAT_W-1:0]         i_pat,
    input  logic [SC_W-1:0]          i_sites,
    input  logic signed [COEF_W-1:0] i_h,
    input  logic signed [COEF_W-1:0] i_v,
    output t_diag_res                o_res
);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_RUN  = 4'b0010,
        D_MUL  = 4'b0100,
        D_SUM  = 4'b1000
    } t_dstate;

    t_dstate r_state, n_state;
    logic                     r_done, n_done;
    logic [SC_W-1:0]          r_i, n_i;
    logic [PAT_W-1:0]         r_pat, n_pat;
    logic [SC_W-1:0]          r_l, n_l;
    logic signed [6:0]        r_a, n_a;
    logic signed [10:0]       r_b, n_b;
    logic signed [17:0]       r_ch, n_ch;
    logic signed [6:0]        r_pre, n_pre;
    logic signed [30:0]       r_pa;
    logic signed [42:0]       r_pd;
    logic signed [VAL_W-1:0]  r_val;

    logic                     bit_s;
    logic                     in_pair;
    logic signed [7:0]        coef_b;
    logic signed [6:0]        coef_c;
    logic signed [13:0]       term_c;
    logic signed [18:0]       diff;

    always_comb begin
        bit_s   = r_pat[r_i[4:0]];
        in_pair = (7'(r_i) + 7'd2) <= 7'(r_l);
        coef_b  = $signed(8'(r_l >> 1)) - $signed(8'((7'(r_i) + 7'd1) >> 1));
        coef_c  = $signed(7'(r_l)) - 7'sd1 - $signed(7'(r_i));
        term_c  = coef_c * r_pre;
        diff    = 19'(r_ch) - 19'(r_b);
    end

    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        n_i     = r_i;
        n_pat   = r_pat;
        n_l     = r_l;
        n_a     = r_a;
        n_b     = r_b;
        n_ch    = r_ch;
        n_pre   = r_pre;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_done  = 1'b0;
                    n_pat   = i_pat;
                    n_l     = i_sites;
                    n_i     = '0;
                    n_a     = '0;
                    n_b     = '0;
                    n_ch    = '0;
                    n_pre   = '0;
                    n_state = (i_sites == '0) ? D_MUL : D_RUN;
                end
            end
            D_RUN: begin
                n_a = (bit_s ^ r_i[0]) ? r_a - 7'sd1 : r_a + 7'sd1;
                if (in_pair) begin
                    n_b   = bit_s ? r_b + 11'(coef_b) : r_b - 11'(coef_b);
                    n_ch  = bit_s ? r_ch + 18'(term_c) : r_ch - 18'(term_c);
                    n_pre = bit_s ? r_pre + 7'sd1 : r_pre - 7'sd1;
                end
                n_i = r_i + 6'd1;
                if (7'(r_i) + 7'd1 >= 7'(r_l)) begin
                    n_state = D_MUL;
                end
            end
            D_MUL: begin
                n_state = D_SUM;
            end
            D_SUM: begin
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_i   <= n_i;
        r_pat <= n_pat;
        r_l   <= n_l;
        r_a   <= n_a;
        r_b   <= n_b;
        r_ch  <= n_ch;
        r_pre <= n_pre;
        if (r_state == D_MUL) begin
            r_pa <= i_h * r_a;
            r_pd <= i_v * diff;
        end
        if (r_state == D_SUM) begin
            r_val <= VAL_W'(r_pa) + VAL_W'(r_pd);
        end
    end

    assign o_res.done  = r_done;
    assign o_res.stag  = r_a;
    assign o_res.value = r_val;

endmodule

@@ rtl/lattice_hamiltonian_row_builder_unit.sv @@
// ----------------------------------------------------------------------------
// lattice_hamiltonian_row_builder_unit
// Builds one Hamiltonian row per in-range row request from a sorted basis table.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        content
//  i_req     in   valid/ready      kind, slot, pattern
//  o_rsp     out  valid/ready      row, column, matrix_value, is_diagonal,
//                                  stag_sum, last
//  i_cfg_*   in   write enable     register index, data
//
//  A load is written into the table when accepted. A row reads its pattern from
//  the table (S_IDLE, S_LOADP), then scans the site pairs in S_SCAN; a differing
//  pair runs a binary search of S_PROBE/S_CMP steps (about log2(basis_count)+1
//  probes, single table read port) and closes with a hop entry in S_EMIT or a
//  miss. The energy unit runs beside the scan; S_DIAG emits the diagonal last.
//  Requests are taken only between rows; a stalled result holds the row.
// ----------------------------------------------------------------------------
module lattice_hamiltonian_row_builder_unit
    import lhrb_pkg::*;
#(
    parameter int MAX_SITES   = 32,
    parameter int BASIS_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lhrb_req_if.sink          i_req,
    lhrb_rsp_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0] i_cfg_data
);

    localparam int AW  = (BASIS_DEPTH > 1) ? $clog2(BASIS_DEPTH) : 1;
    localparam int CW  = $clog2(BASIS_DEPTH + 1);
    localparam int XW  = 17;
    localparam int LIM = (MAX_SITES < 32) ? MAX_SITES : 32;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOADP = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_DIAG  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [SC_W-1:0]          r_site_count;
    logic [BC_W-1:0]          r_basis_count;
    logic signed [COEF_W-1:0] r_h, r_v, r_t;

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [PAT_W-1:0]  r_p, n_p;
    logic [PAT_W-1:0]  r_q, n_q;
    logic [SC_W-1:0]   r_i, n_i;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_len, n_len;
    logic [CW-1:0]     r_mid, n_mid;

    logic                    r_ov;
    logic [SLOT_W-1:0]       r_row, r_col;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_diag;
    logic signed [STAG_W-1:0] r_stag;

    logic [CW-1:0]    cnt_sat;
    logic [SC_W-1:0]  sites;
    logic [PAT_W-1:0] site_mask;
    logic             in_acc, row_go, out_free, load_hop, load_diag, diag_start;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [PAT_W-1:0] mem_rdata;
    logic [1:0]       pair;
    logic [CW-1:0]    mid;
    t_diag_res        dres;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_count  <= 6'd8;
            r_basis_count <= 13'd1;
            r_h           <= '0;
            r_v           <= '0;
            r_t           <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SITE_COUNT:    r_site_count  <= i_cfg_data[SC_W-1:0];
                CFG_BASIS_COUNT:   r_basis_count <= i_cfg_data[BC_W-1:0];
                CFG_ONSITE_COEF:   r_h           <= $signed(i_cfg_data);
                CFG_COUPLING_COEF: r_v           <= $signed(i_cfg_data);
                CFG_HOP_COEF:      r_t           <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        cnt_sat   = (XW'(r_basis_count) > XW'(BASIS_DEPTH)) ? CW'(BASIS_DEPTH)
                                                             : CW'(r_basis_count);
        sites     = (r_site_count > SC_W'(LIM)) ? SC_W'(LIM) : r_site_count;
        site_mask = PAT_W'((33'd1 << sites) - 33'd1);
        in_acc    = i_req.valid && i_req.ready;
        row_go    = in_acc && (i_req.kind == KIND_ROW)
                    && (XW'(i_req.slot) < XW'(cnt_sat));
        mem_we    = in_acc && (i_req.kind == KIND_LOAD)
                    && (XW'(i_req.slot) < XW'(BASIS_DEPTH));
        out_free  = !r_ov || o_rsp.ready;
        pair      = 2'(r_p >> r_i[4:0]);
        mid       = r_len >> 1;
    end

    // ---------------- row sequencer ----------------
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_p        = r_p;
        n_q        = r_q;
        n_i        = r_i;
        n_lo       = r_lo;
        n_len      = r_len;
        n_mid      = r_mid;
        mem_re     = 1'b0;
        mem_raddr  = AW'(i_req.slot);
        load_hop   = 1'b0;
        load_diag  = 1'b0;
        diag_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (row_go) begin
                    n_slot  = i_req.slot;
                    mem_re  = 1'b1;
                    n_state = S_LOADP;
                end
            end
            S_LOADP: begin
                n_p        = mem_rdata & site_mask;
                n_i        = '0;
                diag_start = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (7'(r_i) + 7'd1 >= 7'(sites)) begin
                    n_state = S_DIAG;
                end else if (pair[0] != pair[1]) begin
                    n_q     = r_p ^ PAT_W'(33'd3 << r_i);
                    n_lo    = '0;
                    n_len   = cnt_sat;
                    n_state = S_PROBE;
                end else begin
                    n_i = r_i + 6'd1;
                end
            end
            S_PROBE: begin
                if (r_len == '0) begin
                    n_i     = r_i + 6'd1;
                    n_state = S_SCAN;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_lo + mid);
                    n_mid     = mid;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (mem_rdata == r_q) begin
                    n_state = S_EMIT;
                end else if (mem_rdata < r_q) begin
                    n_lo    = r_lo + r_mid + CW'(1);
                    n_len   = r_len - r_mid - CW'(1);
                    n_state = S_PROBE;
                end else begin
                    n_len   = r_mid;
                    n_state = S_PROBE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load_hop = 1'b1;
                    n_i      = r_i + 6'd1;
                    n_state  = S_SCAN;
                end
            end
            S_DIAG: begin
                if (out_free && dres.done) begin
                    load_diag = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_hop || load_diag) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
        r_slot <= n_slot;
        r_p    <= n_p;
        r_q    <= n_q;
        r_i    <= n_i;
        r_lo   <= n_lo;
        r_len  <= n_len;
        r_mid  <= n_mid;
        if (load_hop) begin
            r_row  <= SLOT_W'(r_lo + r_mid);
            r_col  <= r_slot;
            r_val  <= VAL_W'(r_t);
            r_diag <= 1'b0;
            r_stag <= '0;
        end else if (load_diag) begin
            r_row  <= r_slot;
            r_col  <= r_slot;
            r_val  <= dres.value;
            r_diag <= 1'b1;
            r_stag <= dres.stag;
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.row          = r_row;
    assign o_rsp.column       = r_col;
    assign o_rsp.matrix_value = r_val;
    assign o_rsp.is_diagonal  = r_diag;
    assign o_rsp.stag_sum     = r_stag;
    assign o_rsp.last         = r_diag;

    // ---------------- submodules ----------------
    lhrb_mem #(
        .DEPTH (BASIS_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_req.slot)),
        .i_wdata (i_req.pattern),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lhrb_diag u_diag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (diag_start),
        .i_pat   (n_p),
        .i_sites (sites),
        .i_h     (r_h),
        .i_v     (r_v),
        .o_res   (dres)
    );

    // ---------------- checks ----------------
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_hop || load_diag) |-> (!r_ov || o_rsp.ready))
        else $error("result register overwritten while full");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((XW'(r_lo) + XW'(r_mid)) < XW'(cnt_sat)))
        else $error("search probe beyond table count");

    a_diag_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_diag |-> dres.done)
        else $error("diagonal emitted before energy done");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lattice Hamiltonian row builder: loads sorted
// basis tables, requests rows under several register settings, and checks
// every hop and diagonal entry against a local row predictor.
// ----------------------------------------------------------------------------
module tb;
    import lhrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 4096;
    localparam int ROW_LAT   = 1200;
    localparam int IDLE_LIMIT = 20000;
    localparam int REQ_TARGET = 95;

    typedef struct {
        logic        kind;
        logic [11:0] slot;
        logic [31:0] pattern;
    } t_req;

    typedef struct {
        logic [11:0]        row;
        logic [11:0]        column;
        logic signed [47:0] value;
        logic               diag;
        logic signed [6:0]  stag;
        logic               last;
    } t_entry;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_idx;
    logic [COEF_W-1:0] cfg_data;

    lhrb_req_if req_if ();
    lhrb_rsp_if rsp_if ();

    lattice_hamiltonian_row_builder_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_rsp     (rsp_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0]        basis_mem [DEPTH];
    logic [SC_W-1:0]    m_sites;
    logic [BC_W-1:0]    m_count;
    logic signed [23:0] m_h, m_v, m_t;

    t_req   req_backlog[$];
    t_entry entry_expect_q[$];

    int errors = 0;
    int rows_sent = 0;
    int reqs_queued = 0;
    int entries_seen = 0;
    int hops_seen = 0;
    int idle_cycles = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int find_word(int count, logic [31:0] val);
        int lo, len, mid;
        lo = 0;
        len = count;
        while (len != 0) begin
            mid = len / 2;
            if (basis_mem[lo + mid] == val) return lo + mid;
            if (basis_mem[lo + mid] < val) begin
                lo += mid + 1;
                len -= mid + 1;
            end else begin
                len = mid;
            end
        end
        return -1;
    endfunction

    // applies one accepted request to the predictor and queues its entries
    function automatic void predict_request(t_req r);
        int count, nsite, m, s;
        longint a_sum, b_sum, c_half, prefix, dval;
        logic [31:0] p, q;
        t_entry e;
        if (r.kind == KIND_LOAD) begin
            basis_mem[r.slot] = r.pattern;
            return;
        end
        count = (m_count > DEPTH) ? DEPTH : m_count;
        if (r.slot >= count) return;
        nsite = (m_sites > 32) ? 32 : m_sites;
        p = basis_mem[r.slot] & 32'((64'd1 << nsite) - 1);
        for (int i = 0; i + 1 < nsite; i++) begin
            if (p[i] != p[i+1]) begin
                q = p ^ (32'd3 << i);
                m = find_word(count, q);
                if (m >= 0) begin
                    e.row = m[11:0]; e.column = r.slot; e.value = 48'(longint'(m_t));
                    e.diag = 0; e.stag = 0; e.last = 0;
                    entry_expect_q.insert(entry_expect_q.size(), e);
                end
            end
        end
        a_sum = 0; b_sum = 0; c_half = 0; prefix = 0;
        for (int i = 0; i < nsite; i++) begin
            s = p[i] ? 1 : -1;
            a_sum += (i & 1) ? s : -s;
            if (i <= nsite - 2) begin
                b_sum += (nsite / 2 - (i + 1) / 2) * s;
                c_half += (nsite - 1 - i) * s * prefix;
                prefix += s;
            end
        end
        dval = longint'(m_h) * a_sum - longint'(m_v) * b_sum + longint'(m_v) * c_half;
        e.row = r.slot; e.column = r.slot; e.value = 48'(dval);
        e.diag = 1; e.stag = 7'(a_sum); e.last = 1;
        entry_expect_q.insert(entry_expect_q.size(), e);
    endfunction

    // request driver: bursts with random gaps
    t_req cur_req;
    int   burst_left = 4;
    int   gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_request(cur_req);
                if (cur_req.kind == KIND_ROW) rows_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    req_if.valid <= 1'b0;
                    gap_left--;
                end else if (req_backlog.size() > 0) begin
                    cur_req = req_backlog.pop_front();
                    req_if.kind <= cur_req.kind;
                    req_if.slot <= cur_req.slot;
                    req_if.pattern <= cur_req.pattern;
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_phase = 0;
    t_entry want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                entries_seen++;
                if (!rsp_if.is_diagonal) hops_seen++;
                if (entry_expect_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected entry row=%0d col=%0d", rsp_if.row, rsp_if.column);
                end else begin
                    want = entry_expect_q.pop_front();
                    if (rsp_if.row !== want.row || rsp_if.column !== want.column ||
                        rsp_if.matrix_value !== want.value ||
                        rsp_if.is_diagonal !== want.diag ||
                        rsp_if.stag_sum !== want.stag || rsp_if.last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp row=%0d col=%0d val=%0d diag=%0b stag=%0d last=%0b | got row=%0d col=%0d val=%0d diag=%0b stag=%0d last=%0b",
                                     want.row, want.column, want.value, want.diag,
                                     want.stag, want.last, rsp_if.row, rsp_if.column,
                                     rsp_if.matrix_value, rsp_if.is_diagonal,
                                     rsp_if.stag_sum, rsp_if.last);
                    end
                end
                // long hold-off once, while requests keep coming
                if (!hold_done && req_backlog.size() >= 2) begin
                    hold_left = 300;
                    hold_done = 1'b1;
                end
            end
            stall_phase = (stall_phase + 1) % 100;
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_phase < 50) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("tb failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (req_backlog.size() != 0 || req_if.valid || entry_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (ROW_LAT) @(posedge i_clk);
    endtask

    task automatic write_regs(int sites, int count, int h, int v, int t);
        logic [CIDX_W-1:0] idx [5];
        int vals [5];
        idx = '{CFG_SITE_COUNT, CFG_BASIS_COUNT, CFG_ONSITE_COEF, CFG_COUPLING_COEF,
                CFG_HOP_COEF};
        vals = '{sites, count, h, v, t};
        for (int k = 0; k < 5; k++) begin
            @(posedge i_clk);
            cfg_we <= 1'b1;
            cfg_idx <= idx[k];
            cfg_data <= vals[k][23:0];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        m_sites = sites[SC_W-1:0];
        m_count = count[BC_W-1:0];
        m_h = vals[2][23:0];
        m_v = vals[3][23:0];
        m_t = vals[4][23:0];
    endtask

    function automatic void push_req(logic kind, int slot, logic [31:0] pattern);
        t_req r;
        r.kind = kind;
        r.slot = slot[11:0];
        r.pattern = pattern;
        req_backlog.insert(req_backlog.size(), r);
        reqs_queued++;
    endfunction

    // one setting: new registers, a sorted table of neighbor-rich patterns, rows
    task automatic run_phase(int sites, int count_raw, int h, int v, int t, int nrows);
        logic [31:0] words[$];
        logic [31:0] lmask, w;
        int nsite, n, i;
        wait_idle();
        write_regs(sites, count_raw, h, v, t);
        nsite = (sites % 64 > 32) ? 32 : sites % 64;
        lmask = 32'((64'd1 << nsite) - 1);
        n = (count_raw % 8192 > DEPTH) ? DEPTH : count_raw % 8192;
        while (words.size() < n) begin
            if (words.size() > 0 && nsite >= 2 && $urandom_range(0, 3) != 0) begin
                w = words[$urandom_range(0, words.size() - 1)] & lmask;
                i = $urandom_range(0, nsite - 2);
                if (w[i] != w[i+1]) w = w ^ (32'd3 << i);
                else w = w ^ (32'd1 << i);
            end else begin
                w = $urandom();
                // bits above the site count only now and then
                if ($urandom_range(0, 7) != 0) w = w & lmask;
            end
            words.insert(words.size(), w);
        end
        words.sort();
        for (int k = 0; k < n; k++) push_req(KIND_LOAD, k, words[k]);
        for (int k = 0; k < nrows; k++) begin
            if (n < DEPTH && $urandom_range(0, 9) == 0)
                push_req(KIND_ROW, $urandom_range(n, DEPTH - 1), $urandom());
            else
                push_req(KIND_ROW, $urandom_range(0, n - 1), $urandom());
        end
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.kind = KIND_LOAD;
        req_if.slot = '0;
        req_if.pattern = '0;
        rsp_if.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_SITE_COUNT;
        cfg_data = '0;
        i_rst_n = 1'b0;
        m_sites = 8;
        m_count = 1;
        m_h = 0;
        m_v = 0;
        m_t = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: one-entry table, high bits set, out-of-range rows
        push_req(KIND_LOAD, 0, 32'hFFFF_FFA5);
        push_req(KIND_LOAD, 4095, 32'hFFFF_FFFF);
        push_req(KIND_ROW, 0, 32'h0);
        push_req(KIND_ROW, 1, 32'hFFFF_FFFF);
        push_req(KIND_ROW, 4095, 32'h0);

        // register extremes, tiny, odd and oversized site counts
        run_phase(4, 6, 8388607, -8388608, 8388607, 3);
        run_phase(0, 2, -8388608, 8388607, -8388608, 1);
        run_phase(1, 2, 1, 1, 1, 1);
        run_phase(5, 4, -4096, 4096, 12288, 2);
        run_phase(63, 5, 8388607, 8388607, -1, 2);
        run_phase(32, 4, -8388608, -8388608, 8388607, 2);

        // count beyond the table saturates: a full-length search first probes
        // the middle entry, where the swapped pattern sits
        wait_idle();
        write_regs(2, 8191, $urandom_range(0, 16777215), $urandom_range(0, 16777215),
                   $urandom_range(0, 16777215));
        push_req(KIND_LOAD, 0, 32'h0000_0001);
        push_req(KIND_LOAD, DEPTH / 2, 32'h0000_0002);
        push_req(KIND_ROW, 0, 32'h0);

        run_phase(12, 12, 4096, -8192, 4096, 4);

        // random settings
        while (reqs_queued < REQ_TARGET) begin
            run_phase(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                  : 2 * $urandom_range(1, 8),
                      $urandom_range(1, 16),
                      $urandom_range(0, 16777215), $urandom_range(0, 16777215),
                      $urandom_range(0, 16777215), $urandom_range(3, 6));
        end
        wait_idle();

        $display("covered %0d requests, %0d row requests, %0d entries (%0d hops)",
                 reqs_queued, rows_sent, entries_seen, hops_seen);
        $display("mismatches %0d, entries still expected %0d", errors, entry_expect_q.size());
        if (errors == 0 && entry_expect_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ lattice_hamiltonian_row_builder_unit.f @@
rtl/lhrb_pkg.sv
rtl/lhrb_req_if.sv
rtl/lhrb_rsp_if.sv
rtl/lhrb_mem.sv
rtl/lhrb_diag.sv
rtl/lattice_hamiltonian_row_builder_unit.sv
tb/tb.sv
